### design/hrf_pkg.sv
// hrf_pkg: shared types, constants and the control-store program for the
// HID response framer. No dependencies.
package hrf_pkg;

    // Payload store geometry and frame layout
    localparam int STORE_DEPTH   = 25;
    localparam int HEADER_BYTES  = 5;
    localparam int TRAILER_BYTES = 2;
    localparam int CNT_W         = 5;
    localparam int IDX_W         = 5;
    localparam int PC_W          = 4;

    // Frame byte constants
    localparam logic [7:0] SYNC0    = 8'hAA;
    localparam logic [7:0] SYNC1    = 8'h55;
    localparam logic [7:0] PAD_BYTE = 8'h00;
    localparam logic [7:0] SEQ_MAX  = 8'hFF;
    localparam logic [7:0] SEQ_WRAP = 8'h01;

    // Request action codes
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_END    = 1'b1;

    // Byte source selected by a control word
    typedef enum logic [3:0] {
        SRC_SYNC0,
        SRC_SYNC1,
        SRC_LEN,
        SRC_NLEN,
        SRC_SEQ,
        SRC_PAYLOAD,
        SRC_SUM_LO,
        SRC_SUM_HI,
        SRC_PAD
    } src_t;

    // Jump conditions
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_CNT_ZERO,
        COND_MORE_PAYLOAD,
        COND_ALWAYS
    } cond_t;

    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        src_t  src;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    // Program addresses that are jump targets
    localparam pc_t PC_SYNC0   = 4'd0;
    localparam pc_t PC_PAYLOAD = 4'd5;
    localparam pc_t PC_SUM_LO  = 4'd6;
    localparam pc_t PC_PAD     = 4'd8;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // Store control from the top level
    typedef struct packed {
        logic append;
        logic clear;
    } store_ctl_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic             busy;
        logic             emit;
        logic             last;
        src_t             src;
        logic [IDX_W-1:0] rd_idx;
    } seq_status_t;

    // Control store: one word per step, emit a byte each step
    function automatic ucode_t ucode_word(input pc_t pc);
        ucode_t w;
        begin
            unique case (pc)
                4'd0:    w = '{src: SRC_SYNC0,   cond: COND_NEVER,        target: PC_SYNC0};
                4'd1:    w = '{src: SRC_SYNC1,   cond: COND_NEVER,        target: PC_SYNC0};
                4'd2:    w = '{src: SRC_LEN,     cond: COND_NEVER,        target: PC_SYNC0};
                4'd3:    w = '{src: SRC_NLEN,    cond: COND_NEVER,        target: PC_SYNC0};
                4'd4:    w = '{src: SRC_SEQ,     cond: COND_CNT_ZERO,     target: PC_SUM_LO};
                4'd5:    w = '{src: SRC_PAYLOAD, cond: COND_MORE_PAYLOAD, target: PC_PAYLOAD};
                4'd6:    w = '{src: SRC_SUM_LO,  cond: COND_NEVER,        target: PC_SYNC0};
                4'd7:    w = '{src: SRC_SUM_HI,  cond: COND_NEVER,        target: PC_SYNC0};
                default: w = '{src: SRC_PAD,     cond: COND_ALWAYS,       target: PC_PAD};
            endcase
            return w;
        end
    endfunction

endpackage

### design/hrf_req_if.sv
// hrf_req_if: request channel into the framer (action, payload byte).
// Depends on nothing.
interface hrf_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] payload_byte;

    modport source (output valid, output action, output payload_byte, input ready);
    modport sink   (input valid, input action, input payload_byte, output ready);
endinterface

### design/hrf_frame_if.sv
// hrf_frame_if: frame byte channel out of the framer.
// Depends on nothing.
interface hrf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

### design/hid_response_framer_core.sv
// hid_response_framer_core: top level; byte select, output register and
// sequence number. Depends on hrf_pkg, hrf_req_if, hrf_frame_if,
// hrf_payload_store and hrf_sequencer.
//
// Builds fixed FRAME_BYTES response frames: sync 0xAA 0x55, length
// (payload+2), its complement, sequence number, payload, 16-bit checksum
// low then high, zero padding, last byte flagged. An append request stores
// at most min(25, FRAME_BYTES-7) bytes; extra bytes are dropped. An end
// request starts the microcoded sequencer, which emits one frame byte per
// cycle from its control store while the output is free; the request port
// is held off until the frame's last byte is emitted. Sequence numbers
// start at 0 and run 1..255, wrapping to 1.
module hid_response_framer_core #(
    parameter int FRAME_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    hrf_req_if.sink     req,
    hrf_frame_if.source frame
);

    hrf_pkg::store_ctl_t       store_ctl;
    hrf_pkg::seq_status_t      seq_status;
    logic [7:0]                rd_data;
    logic [hrf_pkg::CNT_W-1:0] count;
    logic [15:0]               sum;
    logic                      req_fire;
    logic                      start;
    logic                      advance;
    logic                      done;
    logic [7:0]                len;
    logic [7:0]                byte_sel;
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                out_byte_reg;
    logic                      out_last_reg;
    logic [7:0]                seq_num_reg, seq_num_next;

    // request handshake
    assign req.ready = !seq_status.busy;
    assign req_fire  = req.valid && req.ready;
    assign start     = req_fire && (req.action == hrf_pkg::ACT_END);
    assign done      = seq_status.emit && seq_status.last;

    assign store_ctl.append = req_fire && (req.action == hrf_pkg::ACT_APPEND);
    assign store_ctl.clear  = done;

    hrf_payload_store #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (store_ctl),
        .wr_data (req.payload_byte),
        .rd_idx  (seq_status.rd_idx),
        .rd_data (rd_data),
        .count   (count),
        .sum     (sum)
    );

    // output slot free or being drained
    assign advance = !out_valid_reg || frame.ready;

    hrf_sequencer #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .advance (advance),
        .count   (count),
        .status  (seq_status)
    );

    // frame byte select
    assign len = 8'(count) + 8'(hrf_pkg::TRAILER_BYTES);

    always_comb
    begin
        unique case (seq_status.src)
            hrf_pkg::SRC_SYNC0:   byte_sel = hrf_pkg::SYNC0;
            hrf_pkg::SRC_SYNC1:   byte_sel = hrf_pkg::SYNC1;
            hrf_pkg::SRC_LEN:     byte_sel = len;
            hrf_pkg::SRC_NLEN:    byte_sel = ~len;
            hrf_pkg::SRC_SEQ:     byte_sel = seq_num_reg;
            hrf_pkg::SRC_PAYLOAD: byte_sel = rd_data;
            hrf_pkg::SRC_SUM_LO:  byte_sel = sum[7:0];
            hrf_pkg::SRC_SUM_HI:  byte_sel = sum[15:8];
            default:              byte_sel = hrf_pkg::PAD_BYTE;
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (seq_status.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // sequence number advances after each frame
    always_comb
    begin
        seq_num_next = seq_num_reg;
        if (done)
        begin
            seq_num_next = (seq_num_reg == hrf_pkg::SEQ_MAX) ? hrf_pkg::SEQ_WRAP
                                                             : seq_num_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seq_num_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            seq_num_reg   <= seq_num_next;
        end
    end

    // output payload, no reset
    always_ff @(posedge clk)
    begin
        if (seq_status.emit)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= seq_status.last;
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_last = out_last_reg;

endmodule

### design/hrf_payload_store.sv
// hrf_payload_store: payload register file, byte count and 16-bit running sum.
// Depends on hrf_pkg.
module hrf_payload_store #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hrf_pkg::store_ctl_t     ctl,
    input  logic [7:0]              wr_data,
    input  logic [hrf_pkg::IDX_W-1:0] rd_idx,
    output logic [7:0]              rd_data,
    output logic [hrf_pkg::CNT_W-1:0] count,
    output logic [15:0]             sum
);

    localparam int ROOM     = FRAME_BYTES - hrf_pkg::HEADER_BYTES - hrf_pkg::TRAILER_BYTES;
    localparam int CAPACITY = (ROOM < hrf_pkg::STORE_DEPTH) ? ROOM : hrf_pkg::STORE_DEPTH;

    logic [7:0]                store_mem [hrf_pkg::STORE_DEPTH];
    logic [7:0]                rd_data_reg;
    logic [hrf_pkg::CNT_W-1:0] count_reg, count_next;
    logic [15:0]               sum_reg, sum_next;
    logic                      wr_en;

    // append only while there is room
    assign wr_en = ctl.append && (count_reg < hrf_pkg::CNT_W'(CAPACITY));

    // count and sum update; end of frame clears both
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        priority if (ctl.clear)
        begin
            count_next = '0;
            sum_next   = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + {8'h00, wr_data};
        end
        else
        begin
            count_next = count_reg;
            sum_next   = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // payload entries, no reset; read index is the sequencer's next index,
    // so the registered byte lines up with the step that selects it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[count_reg] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_idx];
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;
    assign sum     = sum_reg;

endmodule

### design/hrf_sequencer.sv
// hrf_sequencer: step counter over the control store, byte position and
// payload read index; one frame byte per step. Depends on hrf_pkg.
module hrf_sequencer #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      advance,
    input  logic [hrf_pkg::CNT_W-1:0] count,
    output hrf_pkg::seq_status_t      status
);

    localparam int POS_W = $clog2(FRAME_BYTES);

    hrf_pkg::seq_state_t       state_reg, state_next;
    hrf_pkg::pc_t              pc_reg, pc_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [hrf_pkg::IDX_W-1:0] rd_idx_reg, rd_idx_next;
    hrf_pkg::ucode_t           word;
    logic                      emit;
    logic                      is_last;
    logic                      jump;

    assign word    = hrf_pkg::ucode_word(pc_reg);
    assign is_last = (pos_reg == POS_W'(FRAME_BYTES - 1));

    // jump condition decode
    always_comb
    begin
        unique case (word.cond)
            hrf_pkg::COND_NEVER:        jump = 1'b0;
            hrf_pkg::COND_CNT_ZERO:     jump = (count == '0);
            hrf_pkg::COND_MORE_PAYLOAD: jump = (({1'b0, rd_idx_reg} + 1'b1) < {1'b0, count});
            hrf_pkg::COND_ALWAYS:       jump = 1'b1;
            default:                    jump = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hrf_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = hrf_pkg::SEQ_RUN;
                end
            end
            hrf_pkg::SEQ_RUN:
            begin
                if (advance && is_last)
                begin
                    state_next = hrf_pkg::SEQ_IDLE;
                end
            end
            default: state_next = hrf_pkg::SEQ_IDLE;
        endcase
    end

    // outputs and datapath counters
    always_comb
    begin
        emit        = 1'b0;
        pc_next     = pc_reg;
        pos_next    = pos_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            hrf_pkg::SEQ_IDLE:
            begin
                pc_next     = hrf_pkg::PC_SYNC0;
                pos_next    = '0;
                rd_idx_next = '0;
            end
            hrf_pkg::SEQ_RUN:
            begin
                emit = advance;
                if (advance)
                begin
                    pos_next = pos_reg + 1'b1;
                    pc_next  = jump ? word.target : pc_reg + 1'b1;
                    if (word.src == hrf_pkg::SRC_PAYLOAD)
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hrf_pkg::SEQ_IDLE;
            pc_reg     <= hrf_pkg::PC_SYNC0;
            pos_reg    <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            pos_reg    <= pos_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    assign status.busy   = (state_reg == hrf_pkg::SEQ_RUN);
    assign status.emit   = emit;
    assign status.last   = is_last;
    assign status.src    = word.src;
    // store read is registered, so it is addressed with the next step's index
    assign status.rd_idx = rd_idx_next;

endmodule

### design/hrf_checker.sv
// hrf_checker: port-level assertions for hid_response_framer_core, with the
// bind that attaches it. Depends on hrf_pkg and the top level.
module hrf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       req_action,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic [7:0] frame_byte,
    input logic       frame_last
);

    // a stalled frame byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame_byte)
                                        && $stable(frame_last))
    else $error("frame byte changed while stalled");

    // an end request blocks further requests while the frame is built
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == hrf_pkg::ACT_END) |=> !req_ready)
    else $error("request taken right after end");

    // while requests are open only a final frame byte may be pending
    assert property (@(posedge clk) disable iff (!rst_n)
        req_ready && frame_valid |-> frame_last)
    else $error("request port open mid-frame");

    // after a final byte, the next byte shown opens a new frame
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && frame_last |=>
            !frame_valid || ((frame_byte == hrf_pkg::SYNC0) && !frame_last))
    else $error("frame did not start with sync byte");

endmodule

bind hid_response_framer_core hrf_checker u_hrf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_action  (req.action),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.frame_byte),
    .frame_last  (frame.frame_last)
);

### tb/hrf_frame_checker.sv
// hrf_frame_checker: watches the request and frame channels of the framer,
// predicts every frame byte and compares what comes out.
// Depends on hrf_pkg, hrf_req_if and hrf_frame_if.
module hrf_frame_checker #(
    parameter int FRAME_BYTES = 32
) (
    input  logic  clk,
    input  logic  rst_n,
    hrf_req_if    req,
    hrf_frame_if  frame,
    output int    fail_count,
    output int    pending,
    output int    frames_done,
    output int    dropped_appends,
    output int    seq_wraps
);

    // Room for payload: header and checksum must fit in one frame
    localparam int ROOM = FRAME_BYTES - hrf_pkg::HEADER_BYTES - hrf_pkg::TRAILER_BYTES;
    localparam int PAYLOAD_CAP = (ROOM < hrf_pkg::STORE_DEPTH) ? ROOM : hrf_pkg::STORE_DEPTH;

    typedef struct {
        logic [7:0] value;
        logic       last;
        int         pos;
    } frame_beat_t;

    // Predicted framer state
    logic [7:0]                held_bytes [hrf_pkg::STORE_DEPTH];
    logic [hrf_pkg::CNT_W-1:0] held_count;
    logic [15:0]               byte_sum;
    logic [7:0]                frame_seq;

    frame_beat_t      expected_beats [$];

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Lay out one frame from the held payload and queue its bytes
    task automatic predict_frame();
        logic [7:0]  img [FRAME_BYTES];
        logic [7:0]  len;
        frame_beat_t beat;
        begin
            for (int k = 0; k < FRAME_BYTES; k++)
                img[k] = hrf_pkg::PAD_BYTE;
            len    = 8'(held_count) + 8'd2;
            img[0] = hrf_pkg::SYNC0;
            img[1] = hrf_pkg::SYNC1;
            img[2] = len;
            img[3] = ~len;
            img[4] = frame_seq;
            for (int k = 0; k < int'(held_count); k++)
                img[hrf_pkg::HEADER_BYTES + k] = held_bytes[k];
            img[hrf_pkg::HEADER_BYTES + int'(held_count)]     = byte_sum[7:0];
            img[hrf_pkg::HEADER_BYTES + int'(held_count) + 1] = byte_sum[15:8];
            for (int k = 0; k < FRAME_BYTES; k++)
            begin
                beat.value = img[k];
                beat.last  = (k == FRAME_BYTES - 1);
                beat.pos   = k;
                expected_beats.push_back(beat);
            end
            // Sequence skips zero after the first wrap
            if (frame_seq == hrf_pkg::SEQ_MAX)
            begin
                frame_seq = hrf_pkg::SEQ_WRAP;
                seq_wraps++;
            end
            else
                frame_seq = frame_seq + 8'd1;
            held_count = '0;
            byte_sum   = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
        begin
            held_count      = '0;
            byte_sum        = '0;
            frame_seq       = '0;
            fail_count      = 0;
            frames_done     = 0;
            dropped_appends = 0;
            seq_wraps       = 0;
            expected_beats.delete();
            pending         = 0;
        end
        else
        begin
            // Accepted request: append or close the frame
            if (req.valid && req.ready)
            begin
                if (req.action == hrf_pkg::ACT_APPEND)
                begin
                    if (int'(held_count) < PAYLOAD_CAP)
                    begin
                        held_bytes[held_count] = req.payload_byte;
                        held_count             = held_count + 1'b1;
                        byte_sum               = byte_sum + 16'(req.payload_byte);
                    end
                    else
                        dropped_appends++;
                end
                else
                    predict_frame();
            end

            // Accepted frame byte: compare with the oldest prediction
            if (frame.valid && frame.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch($sformatf("frame byte %02h (last=%0b) with nothing expected",
                                              frame.frame_byte, frame.frame_last));
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (frame.frame_byte !== want.value)
                        report_mismatch($sformatf("frame_byte at %0d: got %02h, expected %02h",
                                                  want.pos, frame.frame_byte, want.value));
                    if (frame.frame_last !== want.last)
                        report_mismatch($sformatf("frame_last at %0d: got %0b, expected %0b",
                                                  want.pos, frame.frame_last, want.last));
                    if (want.last)
                        frames_done++;
                end
            end
            pending = expected_beats.size();
        end
    end

endmodule

### tb/hid_response_framer_core_tb.sv
// hid_response_framer_core_tb: drives append and end requests into the framer
// under several idle/stall mixes and gives the verdict from the checker.
// Depends on hrf_pkg, hrf_req_if, hrf_frame_if, hrf_frame_checker and the core.
module hid_response_framer_core_tb;

    localparam int FRAME_BYTES  = 32;
    localparam int LIMIT_CYCLES = 600000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int idle_pct  = 0;
    int stall_pct = 0;
    int req_count = 0;
    int end_count = 0;

    int fail_count;
    int pending;
    int frames_done;
    int dropped_appends;
    int seq_wraps;

    hrf_req_if   req ();
    hrf_frame_if frame ();

    hid_response_framer_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .frame (frame)
    );

    hrf_frame_checker #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .frame           (frame),
        .fail_count      (fail_count),
        .pending         (pending),
        .frames_done     (frames_done),
        .dropped_appends (dropped_appends),
        .seq_wraps       (seq_wraps)
    );

    // 12-unit clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Frame receiver: random back-pressure
    always @(posedge clk)
        frame.ready <= ($urandom_range(0, 99) >= stall_pct);

    // Hold one request until the framer takes it, with random idle cycles first
    task automatic send_req(input logic act, input logic [7:0] value);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.action       <= act;
        req.payload_byte <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        req_count++;
        if (act == hrf_pkg::ACT_END)
            end_count++;
    endtask

    // Random traffic: mostly short frames, some at or past capacity
    task automatic run_phase(input int sender_idle, input int recv_stall, input int quota);
        int sent;
        int n;
        int pick;
        begin
            idle_pct  = sender_idle;
            stall_pct = recv_stall;
            sent      = 0;
            while (sent < quota)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    n = $urandom_range(0, 6);
                else if (pick < 8)
                    n = $urandom_range(7, 24);
                else
                    n = $urandom_range(25, 28);
                repeat (n)
                    send_req(hrf_pkg::ACT_APPEND, 8'($urandom_range(0, 255)));
                send_req(hrf_pkg::ACT_END, 8'($urandom_range(0, 255)));
                sent += n + 1;
            end
        end
    endtask

    // Run limit
    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("** hid_response_framer_core: FAILED **");
        $finish;
    end

    // Stimulus
    initial
    begin
        req.valid        = 1'b0;
        req.action       = hrf_pkg::ACT_APPEND;
        req.payload_byte = 8'h00;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty end: length 2, zero checksum; payload on an end is ignored
        send_req(hrf_pkg::ACT_END, 8'hFF);
        // Extreme payload values
        send_req(hrf_pkg::ACT_APPEND, 8'h00);
        send_req(hrf_pkg::ACT_APPEND, 8'hFF);
        send_req(hrf_pkg::ACT_END, 8'h00);
        // Full store plus appends that must be dropped
        repeat (26)
            send_req(hrf_pkg::ACT_APPEND, 8'hFF);
        send_req(hrf_pkg::ACT_END, 8'h5A);

        run_phase(0, 0, 16);
        run_phase(68, 0, 16);
        run_phase(0, 68, 16);
        run_phase(10, 10, 16);

        // Drain
        req.valid <= 1'b0;
        stall_pct = 0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (FRAME_BYTES + 8)
            @(posedge clk);

        $display("Run covered %0d requests (%0d ends), %0d frames checked,",
                 req_count, end_count, frames_done);
        $display("  %0d appends dropped past capacity, %0d sequence wraps",
                 dropped_appends, seq_wraps);
        if (fail_count == 0)
            $display("** hid_response_framer_core: PASSED **");
        else
            $display("** hid_response_framer_core: FAILED **");
        $finish;
    end

endmodule
